[rtl/pfthp_pkg.sv]
// Shared types and constants for the fragment header parser.
// No dependencies; imported by every module of the block.
package pfthp_pkg;

  localparam logic [7:0] SYNC0 = 8'h50;
  localparam logic [7:0] SYNC1 = 8'h46;

  localparam int FEC_BIT  = 15;
  localparam int ADDR_BIT = 14;
  localparam int LEN_W    = 14;

  localparam int POS_W = 5;
  localparam int LP_W  = 6;

  // header layout positions, with both optional groups present
  localparam logic [LP_W-1:0] LP_SYNC1 = 6'd1;
  localparam logic [LP_W-1:0] LP_SEQ   = 6'd3;
  localparam logic [LP_W-1:0] LP_IDX   = 6'd6;
  localparam logic [LP_W-1:0] LP_CNT   = 6'd9;
  localparam logic [LP_W-1:0] LP_LEN   = 6'd11;
  localparam logic [LP_W-1:0] LP_RSK   = 6'd12;
  localparam logic [LP_W-1:0] LP_RSZ   = 6'd13;
  localparam logic [LP_W-1:0] LP_ADDR  = 6'd14;
  localparam logic [LP_W-1:0] LP_SRC   = 6'd15;
  localparam logic [LP_W-1:0] LP_DST   = 6'd17;
  localparam logic [LP_W-1:0] LP_CRC   = 6'd19;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SYNC = 2'd1;
  localparam logic [1:0] ST_SRC_MISS = 2'd2;
  localparam logic [1:0] ST_DST_MISS = 2'd3;

  localparam logic [1:0] REG_FILTER_EN = 2'd0;
  localparam logic [1:0] REG_WANT_SRC  = 2'd1;
  localparam logic [1:0] REG_WANT_DST  = 2'd2;

  localparam int TDATA_W = 144;

  typedef struct packed {
    logic        filter_en;
    logic [15:0] want_src;
    logic [15:0] want_dst;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [15:0]      seq_number;
    logic [23:0]      frag_index;
    logic [23:0]      frag_count;
    logic [LEN_W-1:0] payload_len;
    logic             has_fec;
    logic [7:0]       rs_k;
    logic [7:0]       rs_z;
    logic [15:0]      src_addr;
    logic [15:0]      dst_addr;
    logic [15:0]      header_crc;
  } res_t;

endpackage

[rtl/pft_header_parser_core.sv]
// Top level of the fragment header parser: input register, config registers,
// parser and result register. Depends on pfthp_pkg, pfthp_parse, pfthp_out_reg.
//
//  channel | direction | payload
//  in_     | slave     | tdata[7:0] data_byte, tuser[0] first_byte
//  out_    | master    | tuser[1:0] status, tdata header fields
//  cfg_    | slave     | cfg_index register, cfg_data value
//
// One byte per cycle unless the result register is full. Each byte is parsed
// from the input register; each result is held in the result register.
// The input register advances whenever the result register is free or drained.
// Synchronous active-low reset; parser comes up idle until a first byte.
module pft_header_parser_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic [0:0]   in_tuser,   // [0] first_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] seq_number, [39:16] frag_index, [63:40] frag_count,
  // [77:64] payload_len, [78] has_fec, [86:79] rs_k, [94:87] rs_z,
  // [110:95] src_addr, [126:111] dst_addr, [142:127] header_crc, [143] zero
  output logic [pfthp_pkg::TDATA_W-1:0] out_tdata,
  output logic [1:0]   out_tuser,  // [1:0] status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import pfthp_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_first_r;
  logic       go;
  logic       slot_free;
  logic       res_vld;
  res_t       res;
  res_t       out_res;
  cfg_t       cfg_r;

  assign go        = in_vld_r && slot_free;
  assign in_tready = !in_vld_r || slot_free;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_first_r <= in_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FILTER_EN: cfg_r.filter_en <= cfg_data[0];
        REG_WANT_SRC:  cfg_r.want_src  <= cfg_data;
        REG_WANT_DST:  cfg_r.want_dst  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pfthp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (go),
    .data_byte  (in_byte_r),
    .first_byte (in_first_r),
    .cfg        (cfg_r),
    .res_vld    (res_vld),
    .res        (res)
  );

  pfthp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go && res_vld),
    .load_data (res),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_res),
    .slot_free (slot_free)
  );

  assign out_tuser = out_res.status;
  assign out_tdata = {1'b0, out_res.header_crc, out_res.dst_addr, out_res.src_addr,
                      out_res.rs_z, out_res.rs_k, out_res.has_fec, out_res.payload_len,
                      out_res.frag_count, out_res.frag_index, out_res.seq_number};

endmodule

[rtl/pfthp_parse.sv]
// Header parser state: byte position, flags, byte shifter and captured fields.
// Depends on pfthp_pkg. Produces at most one result per stepped byte.
module pfthp_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                first_byte,
  input  pfthp_pkg::cfg_t     cfg,
  output logic                res_vld,
  output pfthp_pkg::res_t     res
);
  import pfthp_pkg::*;

  logic [POS_W-1:0] pos_r;
  logic             done_r;
  logic             fec_r;
  logic             addr_r;
  logic [15:0]      shift_r;

  logic [15:0]      seq_r;
  logic [23:0]      idx_r;
  logic [23:0]      cnt_r;
  logic [15:0]      len_r;
  logic [7:0]       rsk_r;
  logic [7:0]       rsz_r;
  logic [15:0]      src_r;
  logic [15:0]      dst_r;

  logic [POS_W-1:0] pos_e;
  logic [15:0]      shift_e;
  logic             fec_e;
  logic             addr_e;
  logic             active;
  logic [23:0]      acc;
  logic             sync_bad;
  logic [LP_W-1:0]  lp0;
  logic [LP_W-1:0]  lp1;
  logic [LP_W-1:0]  lp2;
  logic [1:0]       status;

  always_comb begin
    pos_e    = first_byte ? '0 : pos_r;
    shift_e  = first_byte ? '0 : shift_r;
    fec_e    = first_byte ? 1'b0 : fec_r;
    addr_e   = first_byte ? 1'b0 : addr_r;
    active   = first_byte || !done_r;
    acc      = {shift_e, data_byte};
    sync_bad = ((pos_e == '0) && (data_byte != SYNC0)) ||
               ((pos_e == LP_SYNC1[POS_W-1:0]) && (data_byte != SYNC1));
    lp0 = {1'b0, pos_e};
    lp1 = ((lp0 >= LP_RSK) && !fec_e) ? lp0 + 6'd2 : lp0;
    lp2 = ((lp1 >= LP_ADDR) && !addr_e) ? lp1 + 6'd4 : lp1;
  end

  always_comb begin
    if (cfg.filter_en && (src_r != cfg.want_src)) begin
      status = ST_SRC_MISS;
    end else if (cfg.filter_en && (dst_r != cfg.want_dst)) begin
      status = ST_DST_MISS;
    end else begin
      status = ST_OK;
    end
  end

  assign res_vld = step && active && (sync_bad || (lp2 == LP_CRC));

  always_comb begin
    res = '0;
    if (sync_bad) begin
      res.status = ST_BAD_SYNC;
    end else begin
      res.status      = status;
      res.seq_number  = seq_r;
      res.frag_index  = idx_r;
      res.frag_count  = cnt_r;
      res.payload_len = len_r[LEN_W-1:0];
      res.has_fec     = len_r[FEC_BIT];
      res.rs_k        = rsk_r;
      res.rs_z        = rsz_r;
      res.src_addr    = src_r;
      res.dst_addr    = dst_r;
      res.header_crc  = acc[15:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      done_r  <= 1'b1;
      fec_r   <= 1'b0;
      addr_r  <= 1'b0;
      shift_r <= '0;
    end else if (step && active) begin
      if (sync_bad) begin
        done_r  <= 1'b1;
        pos_r   <= pos_e;
        shift_r <= shift_e;
        fec_r   <= fec_e;
        addr_r  <= addr_e;
      end else begin
        shift_r <= acc[15:0];
        fec_r   <= (lp2 == LP_LEN) ? acc[FEC_BIT] : fec_e;
        addr_r  <= (lp2 == LP_LEN) ? acc[ADDR_BIT] : addr_e;
        if (lp2 == LP_CRC) begin
          done_r <= 1'b1;
          pos_r  <= pos_e;
        end else begin
          done_r <= 1'b0;
          pos_r  <= pos_e + 5'd1;
        end
      end
    end
  end

  // captured fields
  always_ff @(posedge clk) begin
    if (step) begin
      if (first_byte) begin
        seq_r <= '0;
        idx_r <= '0;
        cnt_r <= '0;
        len_r <= '0;
        rsk_r <= '0;
        rsz_r <= '0;
        src_r <= '0;
        dst_r <= '0;
      end else if (active && !sync_bad) begin
        case (lp2)
          LP_SEQ: begin
            seq_r <= acc[15:0];
          end
          LP_IDX: begin
            idx_r <= acc;
          end
          LP_CNT: begin
            cnt_r <= acc;
          end
          LP_LEN: begin
            len_r <= acc[15:0];
          end
          LP_RSK: begin
            rsk_r <= data_byte;
          end
          LP_RSZ: begin
            rsz_r <= data_byte;
          end
          LP_SRC: begin
            src_r <= acc[15:0];
          end
          LP_DST: begin
            dst_r <= acc[15:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

[rtl/pfthp_out_reg.sv]
// Result register: holds one result transaction until the sink takes it.
// Depends on pfthp_pkg.
module pfthp_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  pfthp_pkg::res_t  load_data,
  input  logic             out_ready,
  output logic             out_valid,
  output pfthp_pkg::res_t  out_data,
  output logic             slot_free
);
  import pfthp_pkg::*;

  logic vld_r;
  res_t data_r;

  assign slot_free = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

[tb/sv/pft_header_parser_core_test.sv]
// Self-checking testbench for pft_header_parser_core: fragment headers, broken and
// truncated packets and address filtering, checked against a header predictor.
// Depends on pfthp_pkg and the parser RTL.
module pft_header_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pfthp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 60;

  class header_fields_scoreboard;
    logic [POS_W-1:0] pos;
    logic             waiting_first;
    logic             fec_on;
    logic             addr_on;
    logic [23:0]      recent;
    logic [15:0]      len_word;
    res_t             held;
    logic             filt_en;
    logic [15:0]      want_src;
    logic [15:0]      want_dst;
    res_t             headers_due[$];
    int               headers_total;
    int               errors;

    function new();
      pos = '0;
      waiting_first = 1'b1;
      fec_on = 1'b0;
      addr_on = 1'b0;
      recent = '0;
      len_word = '0;
      held = '0;
      filt_en = 1'b0;
      want_src = '0;
      want_dst = '0;
      headers_total = 0;
      errors = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_FILTER_EN: filt_en = val[0];
        REG_WANT_SRC:  want_src = val;
        REG_WANT_DST:  want_dst = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return headers_due.size();
    endfunction

    function void push_header(res_t r);
      headers_due.push_back(r);
      headers_total++;
    endfunction

    function void take_byte(logic [7:0] b, logic first);
      logic [LP_W-1:0] lp;
      logic [23:0]     acc;
      res_t            r;
      if (first) begin
        pos = '0;
        waiting_first = 1'b0;
        fec_on = 1'b0;
        addr_on = 1'b0;
        recent = '0;
        len_word = '0;
        held = '0;
      end
      if (waiting_first) return;
      if ((pos == 0 && b != SYNC0) || (pos == 1 && b != SYNC1)) begin
        waiting_first = 1'b1;
        r = '0;
        r.status = ST_BAD_SYNC;
        push_header(r);
        return;
      end
      // skip absent optional groups in the layout
      lp = LP_W'(pos);
      if (lp >= LP_RSK && !fec_on) lp = lp + LP_W'(2);
      if (lp >= LP_ADDR && !addr_on) lp = lp + LP_W'(4);
      acc = {recent[15:0], b};
      recent = acc;
      case (lp)
        LP_SEQ: held.seq_number = acc[15:0];
        LP_IDX: held.frag_index = acc;
        LP_CNT: held.frag_count = acc;
        LP_LEN: begin
          len_word = acc[15:0];
          fec_on = acc[FEC_BIT];
          addr_on = acc[ADDR_BIT];
        end
        LP_RSK: held.rs_k = b;
        LP_RSZ: held.rs_z = b;
        LP_SRC: held.src_addr = acc[15:0];
        LP_DST: held.dst_addr = acc[15:0];
        LP_CRC: begin
          held.header_crc = acc[15:0];
          waiting_first = 1'b1;
          r = held;
          r.payload_len = len_word[LEN_W-1:0];
          r.has_fec = len_word[FEC_BIT];
          if (filt_en && held.src_addr != want_src) r.status = ST_SRC_MISS;
          else if (filt_en && held.dst_addr != want_dst) r.status = ST_DST_MISS;
          else r.status = ST_OK;
          push_header(r);
          return;
        end
        default: ;
      endcase
      pos = pos + POS_W'(1);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("mismatch: %s", msg);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_header(logic [TDATA_W-1:0] t, logic [1:0] st);
      res_t want;
      if (headers_due.size() == 0) begin
        report($sformatf("result transaction with none pending, status %0d", st));
        return;
      end
      want = headers_due.pop_front();
      check_field("status", 32'(st), 32'(want.status));
      check_field("seq_number", 32'(t[15:0]), 32'(want.seq_number));
      check_field("frag_index", 32'(t[39:16]), 32'(want.frag_index));
      check_field("frag_count", 32'(t[63:40]), 32'(want.frag_count));
      check_field("payload_len", 32'(t[77:64]), 32'(want.payload_len));
      check_field("has_fec", 32'(t[78]), 32'(want.has_fec));
      check_field("rs_k", 32'(t[86:79]), 32'(want.rs_k));
      check_field("rs_z", 32'(t[94:87]), 32'(want.rs_z));
      check_field("src_addr", 32'(t[110:95]), 32'(want.src_addr));
      check_field("dst_addr", 32'(t[126:111]), 32'(want.dst_addr));
      check_field("header_crc", 32'(t[142:127]), 32'(want.header_crc));
      check_field("pad", 32'(t[143]), 32'(1'b0));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  header_fields_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int items_counted = 0;
  logic [15:0] cur_src = '0;
  logic [15:0] cur_dst = '0;

  pft_header_parser_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (holds_done != hold_requests) begin
      holds_done <= hold_requests;
      hold_left <= hold_len;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.take_byte(in_tdata, in_tuser[0]);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_header(out_tdata, out_tuser);
  end

  function automatic logic [23:0] pick_value(int bits);
    logic [23:0] v;
    logic [23:0] ones;
    ones = (24'h1 << bits) - 24'h1;
    case ($urandom_range(5))
      0: v = '0;
      1: v = ones;
      default: v = 24'($urandom);
    endcase
    return v & ones;
  endfunction

  task send_byte(input logic [7:0] d, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_counted++;
  endtask

  task send_header(input logic [15:0] seq, input logic [23:0] idx, input logic [23:0] cnt,
                   input logic [15:0] lenw, input logic [7:0] k, input logic [7:0] z,
                   input logic [15:0] src, input logic [15:0] dst, input logic [15:0] crc,
                   input int cut, input int sync_fault);
    logic [7:0] hdr[$];
    int n;
    hdr = {SYNC0, SYNC1, seq[15:8], seq[7:0], idx[23:16], idx[15:8], idx[7:0],
           cnt[23:16], cnt[15:8], cnt[7:0], lenw[15:8], lenw[7:0]};
    if (lenw[FEC_BIT]) begin
      hdr.push_back(k);
      hdr.push_back(z);
    end
    if (lenw[ADDR_BIT]) begin
      hdr.push_back(src[15:8]);
      hdr.push_back(src[7:0]);
      hdr.push_back(dst[15:8]);
      hdr.push_back(dst[7:0]);
    end
    hdr.push_back(crc[15:8]);
    hdr.push_back(crc[7:0]);
    if (sync_fault == 1) hdr[0] = hdr[0] ^ 8'($urandom_range(255, 1));
    else if (sync_fault == 2) hdr[1] = hdr[1] ^ 8'($urandom_range(255, 1));
    n = (cut > 0 && cut < hdr.size()) ? cut : hdr.size();
    for (int i = 0; i < n; i++) send_byte(hdr[i], i == 0);
  endtask

  task random_packet();
    int kind;
    int cut;
    int fault;
    logic [15:0] lenw;
    logic [15:0] src;
    logic [15:0] dst;
    kind = $urandom_range(99);
    cut = 0;
    fault = 0;
    lenw = {1'($urandom_range(1)), 1'($urandom_range(1)), 14'(pick_value(14))};
    src = ($urandom_range(2) != 0) ? cur_src : 16'(pick_value(16));
    dst = ($urandom_range(2) != 0) ? cur_dst : 16'(pick_value(16));
    if (kind < 8) begin
      fault = $urandom_range(2, 1);
      cut = fault + $urandom_range(2);
    end else if (kind < 18) begin
      cut = $urandom_range(19, 2);
    end
    send_header(16'(pick_value(16)), pick_value(24), pick_value(24), lenw,
                8'(pick_value(8)), 8'(pick_value(8)), src, dst, 16'(pick_value(16)),
                cut, fault);
    if (kind >= 88) begin
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  task drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task cfg_write(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, val);
  endtask

  task program_filter(input logic en, input logic [15:0] src, input logic [15:0] dst);
    cfg_write(REG_FILTER_EN, {15'h0, en});
    cfg_write(REG_WANT_SRC, src);
    cfg_write(REG_WANT_DST, dst);
    cfg_valid <= 1'b0;
    cur_src = src;
    cur_dst = dst;
    @(posedge clk);
  endtask

  initial begin
    int phase_start;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    program_filter(1'b0, 16'h0000, 16'h0000);

    // bytes before any first byte are ignored
    send_byte(8'hA5, 1'b0);
    send_byte(SYNC0, 1'b0);
    // bad sync on the first and on the second byte
    send_byte(8'h00, 1'b1);
    send_byte(SYNC0, 1'b1);
    send_byte(8'hFF, 1'b0);
    // restart mid-header
    send_header(16'h1234, 24'h56789A, 24'hBCDEF0, 16'hC123, 8'h11, 8'h22,
                16'h3344, 16'h5566, 16'h7788, 6, 0);
    send_header('1, '1, '1, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0);
    send_byte(SYNC0, 1'b0);
    send_header('0, '0, '0, 16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 0, 0);
    send_header(16'hA55A, 24'h000001, 24'h800000, 16'h8155, 8'hC3, 8'h3C, 16'h0, 16'h0,
                16'h0F0F, 0, 0);
    send_header(16'h5AA5, 24'h7FFFFF, 24'h000002, 16'h42AA, 8'h0, 8'h0, 16'h8001,
                16'h7FFE, 16'hF0F0, 0, 0);
    drain();
    // address filter: pass, source miss, destination miss, absent addresses
    program_filter(1'b1, 16'h1234, 16'hABCD);
    send_header(16'h1, 24'h1, 24'h2, 16'hC010, 8'h1, 8'h2, 16'h1234, 16'hABCD, 16'h9, 0, 0);
    send_header(16'h2, 24'h1, 24'h2, 16'h4010, 8'h0, 8'h0, 16'h1235, 16'hABCD, 16'h9, 0, 0);
    send_header(16'h3, 24'h1, 24'h2, 16'h4010, 8'h0, 8'h0, 16'h1234, 16'hABCC, 16'h9, 0, 0);
    send_header(16'h4, 24'h1, 24'h2, 16'h0010, 8'h0, 8'h0, 16'h0, 16'h0, 16'h9, 0, 0);

    for (int phase = 0; phase < 12 && (phase < 5 || items_counted < 550); phase++) begin
      drain();
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 82; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 82; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      case (phase)
        0: program_filter(1'b0, 16'h0000, 16'h0000);
        1: program_filter(1'b1, 16'h0000, 16'h0000);
        2: program_filter(1'b1, 16'hFFFF, 16'hFFFF);
        3: program_filter(1'b1, 16'($urandom), 16'($urandom));
        4: program_filter(1'b0, 16'($urandom), 16'($urandom));
        default: program_filter(1'($urandom_range(1)), 16'($urandom), 16'($urandom));
      endcase
      if (phase == 4) begin
        // long receiver hold-off while the sender keeps pushing
        hold_len = 400;
        hold_requests = hold_requests + 1;
        repeat (6) random_packet();
      end
      phase_start = items_counted;
      while (items_counted - phase_start < PHASE_ITEMS) random_packet();
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
